// ----- rtl/nearest_box_match_blend_top_defines.svh -----
// Assertion helpers for the box match block.
`ifndef NEAREST_BOX_MATCH_BLEND_TOP_DEFINES_SVH
`define NEAREST_BOX_MATCH_BLEND_TOP_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define NBM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define NBM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/nbm_pkg.sv -----
package nbm_pkg;

   localparam int REF_DEPTH = 64;
   localparam int REF_AW    = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
   localparam int REF_CW    = $clog2(REF_DEPTH + 1);

   localparam int COORD_W   = 20;
   localparam int SIZE_W    = 16;
   localparam int SCORE_W   = 16;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam int CENTERS_W = 3 * COORD_W;
   localparam int ATTR_W    = 3 * SIZE_W + SCORE_W + 1;

   // request codes
   localparam logic [1:0] REQ_CLEAR   = 2'd0;
   localparam logic [1:0] REQ_APPEND  = 2'd1;
   localparam logic [1:0] REQ_CORRECT = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GATE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_BLEND = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_BLEND   = 2'd2;

   localparam logic [CSR_W-1:0] GATE_RESET         = 16'd1000;
   localparam logic [CSR_W-1:0] CENTER_BLEND_RESET = 16'd22938;
   localparam logic [CSR_W-1:0] SIZE_BLEND_RESET   = 16'd13107;

   typedef struct packed {
      logic [1:0]                req_type;
      logic signed [COORD_W-1:0] center_x;
      logic signed [COORD_W-1:0] center_y;
      logic signed [COORD_W-1:0] center_z;
      logic [SIZE_W-1:0]         size_x;
      logic [SIZE_W-1:0]         size_y;
      logic [SIZE_W-1:0]         size_z;
      logic                      enhanced_flag;
      logic [SCORE_W-1:0]        confidence;
   } req_payload_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_center_x;
      logic signed [COORD_W-1:0] out_center_y;
      logic signed [COORD_W-1:0] out_center_z;
      logic [SIZE_W-1:0]         out_size_x;
      logic [SIZE_W-1:0]         out_size_y;
      logic [SIZE_W-1:0]         out_size_z;
      logic                      out_enhanced_flag;
      logic [SCORE_W-1:0]        out_confidence;
      logic                      matched;
   } rsp_payload_type;

endpackage

// ----- rtl/nbm_ram.sv -----
module nbm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/nearest_box_match_blend_top.sv -----
// Gated nearest-box association with blend. A clear or append request is taken in idle
// and gives no result; an append to a full store is dropped. A correction request
// scans the stored reference centers one per cycle out of the center memory, through a
// three-stage squared-distance pipeline, then reads the winning entry back and blends.
// With an empty store it goes straight to the output stage. One request is in work at
// a time; the result sits in an output register, so the next request can be taken
// while it waits for a transfer.
// Reference memories need no clearing after reset.
`include "nearest_box_match_blend_top_defines.svh"

module nearest_box_match_blend_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  nbm_pkg::req_payload_type        req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output nbm_pkg::rsp_payload_type        rsp_data,
   input  logic                            csr_we,
   input  logic [nbm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [nbm_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int AW    = nbm_pkg::REF_AW;
   localparam int CW    = nbm_pkg::REF_CW;
   localparam int CRW   = nbm_pkg::COORD_W;
   localparam int SZW   = nbm_pkg::SIZE_W;
   localparam int SCW   = nbm_pkg::SCORE_W;
   localparam int KW    = nbm_pkg::CSR_W;
   localparam int DW    = CRW + 1;          // center difference
   localparam int SDW   = SZW + 1;          // size difference
   localparam int SQW   = 2 * DW;
   localparam int SUMW  = SQW + 2;
   localparam int PCW   = DW + KW + 1;
   localparam int PSW   = SDW + KW + 1;
   localparam logic [CW-1:0] DEPTH_C = CW'(nbm_pkg::REF_DEPTH);
   localparam logic signed [PCW-1:0] RND_C = PCW'(1) << (KW - 1);
   localparam logic signed [PSW-1:0] RND_S = PSW'(1) << (KW - 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_DRAIN, ST_FETCH, ST_LOAD, ST_MULT, ST_OUT
   } state_type;

   // ---------------- control ----------------
   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             iss_ff, iss_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   nbm_pkg::rsp_payload_type  rsp_data_ff, rsp_data_in;
   logic [KW-1:0]             gate_ff, center_blend_ff, size_blend_ff;

   logic req_fire, append_we, scan_last, out_free;

   // ---------------- memories ----------------
   logic [AW-1:0]                  rd_addr;
   logic [nbm_pkg::CENTERS_W-1:0]  cen_wdata, cen_rdata;
   logic [nbm_pkg::ATTR_W-1:0]     attr_wdata, attr_rdata;

   // ---------------- datapath ----------------
   nbm_pkg::req_payload_type  box_ff;
   logic signed [CRW-1:0]     box_c [3];
   logic [SZW-1:0]            box_s [3];
   logic signed [CRW-1:0]     ref_c [3];
   logic [SZW-1:0]            ref_s [3];

   logic                      p0_vld_ff, p1_vld_ff, p2_vld_ff;
   logic                      p0_last_ff, p1_last_ff, p2_last_ff;
   logic [AW-1:0]             p0_idx_ff, p1_idx_ff, p2_idx_ff;
   logic signed [DW-1:0]      sd_ff [3];
   logic [SQW-1:0]            sq_ff [3];
   logic [SUMW-1:0]           dist_in;
   logic                      take_best;
   logic                      found_ff;
   logic [SUMW-1:0]           best_sq_ff;
   logic [AW-1:0]             best_idx_ff;
   logic [2*KW-1:0]           gate_sq_ff;
   logic                      match_ff;

   logic signed [DW-1:0]      bd_c_ff [3];
   logic signed [SDW-1:0]     bd_s_ff [3];
   logic signed [PCW-1:0]     prod_c_ff [3];
   logic signed [PSW-1:0]     prod_s_ff [3];
   logic signed [PCW-1:0]     rnd_c [3];
   logic signed [PSW-1:0]     rnd_s [3];
   logic signed [CRW-1:0]     out_c [3];
   logic [SZW-1:0]            out_s [3];
   logic                      ref_flag_ff;
   logic [SCW-1:0]            ref_score_ff;

   assign req_fire  = req_valid && req_ready;
   assign append_we = req_fire && (req_data.req_type == nbm_pkg::REQ_APPEND)
                      && (count_ff < DEPTH_C);
   assign scan_last = (CW'(iss_ff) == (count_ff - CW'(1)));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign cen_wdata  = {req_data.center_z, req_data.center_y, req_data.center_x};
   assign attr_wdata = {req_data.enhanced_flag, req_data.confidence,
                        req_data.size_z, req_data.size_y, req_data.size_x};
   assign rd_addr    = (state_ff == ST_FETCH) ? best_idx_ff : iss_ff;

   nbm_ram #(.WIDTH(nbm_pkg::CENTERS_W), .DEPTH(nbm_pkg::REF_DEPTH)) u_centers (
      .clock   (clock),
      .wr_en   (append_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (cen_wdata),
      .rd_addr (rd_addr),
      .rd_data (cen_rdata)
   );

   nbm_ram #(.WIDTH(nbm_pkg::ATTR_W), .DEPTH(nbm_pkg::REF_DEPTH)) u_attrs (
      .clock   (clock),
      .wr_en   (append_we),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (attr_wdata),
      .rd_addr (rd_addr),
      .rd_data (attr_rdata)
   );

   // field views
   assign box_c[0] = box_ff.center_x;
   assign box_c[1] = box_ff.center_y;
   assign box_c[2] = box_ff.center_z;
   assign box_s[0] = box_ff.size_x;
   assign box_s[1] = box_ff.size_y;
   assign box_s[2] = box_ff.size_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ref_c[i] = cen_rdata[i*CRW +: CRW];
         ref_s[i] = attr_rdata[i*SZW +: SZW];
      end
   end

   // distance and best-entry compare
   assign dist_in   = SUMW'(sq_ff[0]) + SUMW'(sq_ff[1]) + SUMW'(sq_ff[2]);
   assign take_best = p2_vld_ff && (!found_ff || (dist_in < best_sq_ff));

   // blend outputs: box + floor((d * k + half) / 2^16)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rnd_c[i] = (prod_c_ff[i] + RND_C) >>> KW;
         rnd_s[i] = (prod_s_ff[i] + RND_S) >>> KW;
         out_c[i] = match_ff ? (box_c[i] + rnd_c[i][CRW-1:0]) : box_c[i];
         out_s[i] = match_ff ? (box_s[i] + rnd_s[i][SZW-1:0]) : box_s[i];
      end
   end

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      iss_in       = iss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            iss_in = '0;
            if (req_fire) begin
               case (req_data.req_type)
                  nbm_pkg::REQ_CLEAR:   count_in = '0;
                  nbm_pkg::REQ_APPEND:  if (append_we) count_in = count_ff + CW'(1);
                  nbm_pkg::REQ_CORRECT: state_in = (count_ff == '0) ? ST_OUT : ST_SCAN;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end
         ST_SCAN: begin
            iss_in = iss_ff + AW'(1);
            if (scan_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: if (p2_vld_ff && p2_last_ff) state_in = ST_FETCH;
         ST_FETCH: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MULT;
         ST_MULT:  state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in                  = 1'b1;
               rsp_data_in.out_center_x      = out_c[0];
               rsp_data_in.out_center_y      = out_c[1];
               rsp_data_in.out_center_z      = out_c[2];
               rsp_data_in.out_size_x        = out_s[0];
               rsp_data_in.out_size_y        = out_s[1];
               rsp_data_in.out_size_z        = out_s[2];
               rsp_data_in.out_enhanced_flag = box_ff.enhanced_flag |
                                               (match_ff & ref_flag_ff);
               rsp_data_in.out_confidence    =
                  (match_ff && (ref_score_ff > box_ff.confidence)) ?
                  ref_score_ff : box_ff.confidence;
               rsp_data_in.matched           = match_ff;
               state_in                      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         iss_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
         gate_ff         <= nbm_pkg::GATE_RESET;
         center_blend_ff <= nbm_pkg::CENTER_BLEND_RESET;
         size_blend_ff   <= nbm_pkg::SIZE_BLEND_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         iss_ff       <= iss_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               nbm_pkg::CSR_GATE:         gate_ff         <= csr_wdata;
               nbm_pkg::CSR_CENTER_BLEND: center_blend_ff <= csr_wdata;
               nbm_pkg::CSR_SIZE_BLEND:   size_blend_ff   <= csr_wdata;
               default:                   gate_ff         <= gate_ff;
            endcase
         end
      end
      rsp_data_ff <= rsp_data_in;
   end

   // scan pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         p0_vld_ff <= 1'b0;
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
      end else begin
         p0_vld_ff <= (state_ff == ST_SCAN);
         p1_vld_ff <= p0_vld_ff;
         p2_vld_ff <= p1_vld_ff;
         if (req_fire) begin
            found_ff <= 1'b0;
         end else if (take_best) begin
            found_ff <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         box_ff <= req_data;
      end
      gate_sq_ff <= gate_ff * gate_ff;

      // read issue -> difference -> square -> compare
      p0_last_ff <= scan_last;
      p0_idx_ff  <= iss_ff;
      p1_last_ff <= p0_last_ff;
      p1_idx_ff  <= p0_idx_ff;
      p2_last_ff <= p1_last_ff;
      p2_idx_ff  <= p1_idx_ff;
      for (int i = 0; i < 3; i++) begin
         sd_ff[i] <= DW'(ref_c[i]) - DW'(box_c[i]);
         sq_ff[i] <= $unsigned(SQW'(sd_ff[i]) * SQW'(sd_ff[i]));
      end
      if (take_best) begin
         best_sq_ff  <= dist_in;
         best_idx_ff <= p2_idx_ff;
      end

      // winner readback and blend products
      if (state_ff == ST_FETCH) begin
         match_ff <= found_ff && (best_sq_ff <= SUMW'(gate_sq_ff));
      end else if (req_fire) begin
         match_ff <= 1'b0;
      end
      if (state_ff == ST_LOAD) begin
         for (int i = 0; i < 3; i++) begin
            bd_c_ff[i] <= DW'(ref_c[i]) - DW'(box_c[i]);
            bd_s_ff[i] <= $signed({1'b0, ref_s[i]}) - $signed({1'b0, box_s[i]});
         end
         ref_score_ff <= attr_rdata[3*SZW +: SCW];
         ref_flag_ff  <= attr_rdata[3*SZW + SCW];
      end
      for (int i = 0; i < 3; i++) begin
         prod_c_ff[i] <= PCW'(bd_c_ff[i]) * $signed(PCW'({1'b0, center_blend_ff}));
         prod_s_ff[i] <= PSW'(bd_s_ff[i]) * $signed(PSW'({1'b0, size_blend_ff}));
      end
   end

   // ---------------- checks ----------------
   `NBM_ASSERT_SAME(a_rsp_from_out, $rose(rsp_valid_ff), $past(state_ff) == ST_OUT, "result without correction")
   `NBM_ASSERT_NEXT(a_append_count, append_we, count_ff == $past(count_ff) + CW'(1), "append did not advance count")
   `NBM_ASSERT_SAME(a_scan_in_range, state_ff == ST_SCAN, CW'(iss_ff) < count_ff, "scan past stored entries")

endmodule
